[hw/rtl/sksq_pkg.sv]
`timescale 1ns / 1ps

package sksq_pkg;

    // Sequencer phases, also reported in every result
    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_KEY     = 3'd1,
        PH_DECRYPT = 3'd2,
        PH_START   = 3'd3,
        PH_FAIL    = 3'd4
    } t_phase;

    // Request kinds
    typedef enum logic [1:0] {
        FN_TICK    = 2'd0,
        FN_SERIAL  = 2'd1,
        FN_SECTION = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_ON_AFTER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_FLASH_AFTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FAIL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD   = 3'd4;

    localparam logic [15:0] RST_INIT_TIMEOUT    = 16'd15000;
    localparam logic [15:0] RST_LED_ON_AFTER    = 16'd10000;
    localparam logic [15:0] RST_LED_FLASH_AFTER = 16'd30000;
    localparam logic [15:0] RST_KEY_FAIL        = 16'd45000;
    localparam logic [15:0] RST_FLASH_PERIOD    = 16'd500;

    localparam logic [15:0] MS_MAX = 16'hFFFF;

    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic [15:0] init_timeout;
        logic [15:0] led_on_after;
        logic [15:0] led_flash_after;
        logic [15:0] key_fail;
        logic [15:0] flash_period;
    } t_cfg;

    typedef struct packed {
        t_func       func;
        logic [7:0]  data;
        logic        more_pending;
        logic        last;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic        led;
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        out_last;
        logic [5:0]  key_count;
    } t_result;

endpackage

[hw/rtl/serial_key_unlock_sequencer.sv]
`timescale 1ns / 1ps
// A request is held in the input register, its result then in the output register.
// One request per cycle if unstalled; input register, one state update, two-entry skid buffer.
// The key byte for the next section byte is prefetched from the key RAM, so no read stall.
// Reset: i_rst_n synchronous, active low; clears phase, timers, LED, key length and position,
// and reloads the configuration defaults. The key RAM is not cleared.
module serial_key_unlock_sequencer
    import sksq_pkg::*;
#(
    parameter int KEY_CAPACITY = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,  // [7:0] data, [8] more_pending
    input  logic [1:0]           i_s_axis_tuser,  // [1:0] func
    input  logic                 i_s_axis_tlast,  // last section byte
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [23:0]          o_m_axis_tdata,  // [2:0] phase, [3] led, [11:4] out_byte,
                                                  // [17:12] key_count
    output logic                 o_m_axis_tuser,  // [0] byte_valid
    output logic                 o_m_axis_tlast,  // out_last
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg    cfg;
    t_item   in_item;
    t_result core_res;
    t_result out_res;
    logic    core_valid;
    logic    buf_ready;

    // unpack the request
    assign in_item.func         = t_func'(i_s_axis_tuser);
    assign in_item.data         = i_s_axis_tdata[7:0];
    assign in_item.more_pending = i_s_axis_tdata[8];
    assign in_item.last         = i_s_axis_tlast;

    sksq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // phase tracking, timers, LED and key XOR
    sksq_core #(
        .KEY_CAPACITY (KEY_CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_item      (in_item),
        .i_cfg       (cfg),
        .o_res_valid (core_valid),
        .i_res_ready (buf_ready),
        .o_result    (core_res)
    );

    // output register plus skid slot decouples the sink's ready
    sksq_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (core_valid),
        .o_ready  (buf_ready),
        .i_result (core_res),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_res)
    );

    assign o_m_axis_tdata = {6'd0, out_res.key_count, out_res.out_byte, out_res.led,
                             out_res.phase};
    assign o_m_axis_tuser = out_res.byte_valid;
    assign o_m_axis_tlast = out_res.out_last;

endmodule

[hw/rtl/sksq_ram.sv]
`timescale 1ns / 1ps

module sksq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/sksq_cfg.sv]
`timescale 1ns / 1ps

module sksq_cfg
    import sksq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken; indexes past the list are dropped
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INIT_TIMEOUT:    n_cfg.init_timeout    = i_cfg_data;
                CFG_LED_ON_AFTER:    n_cfg.led_on_after    = i_cfg_data;
                CFG_LED_FLASH_AFTER: n_cfg.led_flash_after = i_cfg_data;
                CFG_KEY_FAIL:        n_cfg.key_fail        = i_cfg_data;
                CFG_FLASH_PERIOD:    n_cfg.flash_period    = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_timeout    <= RST_INIT_TIMEOUT;
            r_cfg.led_on_after    <= RST_LED_ON_AFTER;
            r_cfg.led_flash_after <= RST_LED_FLASH_AFTER;
            r_cfg.key_fail        <= RST_KEY_FAIL;
            r_cfg.flash_period    <= RST_FLASH_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/sksq_skid.sv]
`timescale 1ns / 1ps

module sksq_skid
    import sksq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    // ready depends on the skid slot only, so no path from the sink
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_main_valid || i_ready) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_main <= r_skid;
            end
        end else if (i_valid) begin
            if (!r_main_valid || i_ready) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

[hw/rtl/sksq_core.sv]
`timescale 1ns / 1ps

module sksq_core
    import sksq_pkg::*;
#(
    parameter int KEY_CAPACITY = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_result
);

    localparam int LEN_W = $clog2(KEY_CAPACITY + 1);
    localparam int POS_W = (KEY_CAPACITY > 1) ? $clog2(KEY_CAPACITY) : 1;

    // input register
    logic  r_in_valid;
    t_item r_item;

    // sequencer state
    t_phase           r_phase,     n_phase;
    logic [15:0]      r_elapsed,   n_elapsed;
    logic [15:0]      r_flash,     n_flash;
    logic             r_led,       n_led;
    logic [LEN_W-1:0] r_key_len,   n_key_len;
    logic [POS_W-1:0] r_key_pos,   n_key_pos;

    logic             fire;
    logic [15:0]      elapsed_inc;
    logic [15:0]      flash_inc;
    logic             init_fail;
    logic             key_fail;
    logic [LEN_W-1:0] pos_inc;
    logic             key_room;
    logic             key_we;
    logic [7:0]       key_rdata;
    logic [7:0]       key_byte;
    logic [LEN_W+5:0] len_ext;
    t_result          res;

    assign fire       = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_item;
        end
    end

    // saturating counters and limit compares
    assign elapsed_inc = (r_elapsed == MS_MAX) ? MS_MAX : r_elapsed + 16'd1;
    assign flash_inc   = (r_flash == MS_MAX) ? MS_MAX : r_flash + 16'd1;
    assign init_fail   = elapsed_inc >= i_cfg.init_timeout;
    assign key_fail    = elapsed_inc >= i_cfg.key_fail;
    assign key_room    = r_key_len < LEN_W'(KEY_CAPACITY);
    assign pos_inc     = LEN_W'(r_key_pos) + LEN_W'(1);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (fire) begin
            case (r_phase)
                PH_INIT: begin
                    if (r_item.func == FN_TICK && init_fail) begin
                        n_phase = PH_FAIL;
                    end else if (r_item.func == FN_SERIAL && r_item.data == CH_A
                                 && !r_item.more_pending) begin
                        n_phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (r_item.func == FN_TICK && key_fail) begin
                        n_phase = PH_FAIL;
                    end else if (r_item.func == FN_SERIAL && r_item.data == CH_LF) begin
                        n_phase = PH_DECRYPT;
                    end
                end
                PH_DECRYPT: begin
                    if (r_item.func == FN_SECTION && r_item.last) begin
                        n_phase = PH_START;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    assign len_ext = {6'd0, n_key_len};

    // timers, LED, key store and result
    always_comb begin
        n_elapsed = r_elapsed;
        n_flash   = r_flash;
        n_led     = r_led;
        n_key_len = r_key_len;
        n_key_pos = r_key_pos;
        key_we    = 1'b0;
        key_byte  = 8'd0;
        res.byte_valid = 1'b0;
        res.out_byte   = 8'd0;
        res.out_last   = 1'b0;
        if (fire) begin
            case (r_phase)
                PH_INIT: begin
                    if (r_item.func == FN_TICK) begin
                        n_elapsed = elapsed_inc;
                        if (init_fail) begin
                            n_led = 1'b0;
                        end
                    end else if (r_item.func == FN_SERIAL && r_item.data == CH_A
                                 && !r_item.more_pending) begin
                        // key timer restarts on entry to key wait
                        n_elapsed = 16'd0;
                        n_flash   = MS_MAX;
                    end
                end
                PH_KEY: begin
                    if (r_item.func == FN_TICK) begin
                        n_elapsed = elapsed_inc;
                        if (key_fail) begin
                            n_led = 1'b0;
                        end else if (elapsed_inc < i_cfg.led_on_after) begin
                            n_led   = 1'b0;
                            n_flash = MS_MAX;
                        end else if (elapsed_inc < i_cfg.led_flash_after) begin
                            n_led   = 1'b1;
                            n_flash = MS_MAX;
                        end else if (r_flash >= i_cfg.flash_period) begin
                            n_led   = !r_led;
                            n_flash = 16'd0;
                        end else begin
                            n_flash = flash_inc;
                        end
                    end else if (r_item.func == FN_SERIAL) begin
                        if (r_item.data == CH_LF) begin
                            n_led     = 1'b0;
                            n_key_pos = '0;
                        end else if (r_item.data != CH_CR && key_room) begin
                            key_we    = 1'b1;
                            n_key_len = r_key_len + LEN_W'(1);
                        end
                    end
                end
                PH_DECRYPT: begin
                    if (r_item.func == FN_SECTION) begin
                        // read data already holds the entry at r_key_pos
                        if (r_key_len != '0) begin
                            key_byte  = key_rdata;
                            n_key_pos = (pos_inc >= r_key_len) ? '0 : pos_inc[POS_W-1:0];
                        end
                        res.byte_valid = 1'b1;
                        res.out_byte   = r_item.data ^ key_byte;
                        res.out_last   = r_item.last;
                    end
                end
                default: n_led = r_led;
            endcase
        end
        res.phase     = n_phase;
        res.led       = n_led;
        res.key_count = len_ext[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_INIT;
            r_elapsed <= 16'd0;
            r_flash   <= 16'd0;
            r_led     <= 1'b0;
            r_key_len <= '0;
            r_key_pos <= '0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_flash   <= n_flash;
            r_led     <= n_led;
            r_key_len <= n_key_len;
            r_key_pos <= n_key_pos;
        end
    end

    // read address runs one step ahead so the next key byte is ready
    sksq_ram #(
        .WIDTH (8),
        .DEPTH (KEY_CAPACITY),
        .AW    (POS_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_key_len[POS_W-1:0]),
        .i_wdata (r_item.data),
        .i_raddr (n_key_pos),
        .o_rdata (key_rdata)
    );

    assign o_res_valid = fire;
    assign o_result    = res;

`ifndef NO_ASSERTIONS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_len <= LEN_W'(KEY_CAPACITY))
        else $error("key length beyond capacity");

    a_pos_in_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DECRYPT && r_key_len != '0) |-> (LEN_W'(r_key_pos) < r_key_len))
        else $error("key position outside stored key");

    a_start_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START) |=> (r_phase == PH_START))
        else $error("left start phase");

    a_fail_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FAIL) |=> (r_phase == PH_FAIL && !r_led))
        else $error("left failure phase or LED on");

    a_byte_in_decrypt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.byte_valid) |-> (r_phase == PH_DECRYPT && !key_we))
        else $error("decrypted byte outside decrypt phase");
`endif

endmodule
